// File: hw/rtl/sorted_merge_dedup_macros.svh
// Assertion macros shared by the sorted merge checker.
`ifndef SORTED_MERGE_DEDUP_MACROS_SVH
`define SORTED_MERGE_DEDUP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SMD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SMD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/smd_pkg.sv
// Shared types and constants for the sorted merge with duplicate removal.
package smd_pkg;

  // Fixed field widths of the item and result channels.
  localparam int OP_W  = 2;
  localparam int KEY_W = 32;
  localparam int TAG_W = 16;

  // Defaults and upper bound of the list depth.
  localparam int LIST_DEPTH_DEF = 32;
  localparam int TAG_WIDTH_DEF  = 16;
  localparam int LIST_DEPTH_MAX = 32;

  // Count field width in a queued command; holds counts up to LIST_DEPTH_MAX.
  localparam int CNT_FIELD_W = $clog2(LIST_DEPTH_MAX + 1);

  // Number of commands the front can run ahead of the back.
  localparam int QUEUE_DEPTH = 4;

  // Item operation codes.
  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

  // Command kinds passed from the front to the back.
  typedef enum logic [1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_RUN  = 2'd2
  } cmd_kind_t;

  // One queued command. For writes, cnt_a holds the target address.
  typedef struct packed {
    cmd_kind_t                kind;
    logic [CNT_FIELD_W-1:0]   cnt_a;
    logic [CNT_FIELD_W-1:0]   cnt_b;
    logic                     ovf;
    logic signed [KEY_W-1:0]  key;
    logic [TAG_W-1:0]         tag;
  } cmd_t;

endpackage

// File: hw/rtl/smd_stream_if.sv
// Valid/ready channel interfaces for items and results.
interface smd_in_if;
  import smd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [KEY_W-1:0] key;
  logic [TAG_W-1:0]        tag;

  modport source (output valid, output op, output key, output tag, input ready);
  modport sink (input valid, input op, input key, input tag, output ready);
endinterface

interface smd_out_if;
  import smd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] out_key;
  logic [TAG_W-1:0]        out_tag;
  logic                    from_second;
  logic                    is_empty;
  logic                    dropped_any;
  logic                    last;

  modport source (output valid, output out_key, output out_tag, output from_second,
                  output is_empty, output dropped_any, output last, input ready);
  modport sink (input valid, input out_key, input out_tag, input from_second,
                input is_empty, input dropped_any, input last, output ready);
endinterface

// File: hw/rtl/smd_cmd_fifo.sv
// Short command queue between the front and the back.
module smd_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  smd_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output smd_pkg::cmd_t pop_cmd
);
  import smd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  // Handshake on both sides.
  assign push_ready = (fill != NW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  // Pointer advance with wrap at the queue depth.
  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/smd_front.sv
// Front part: accepts items, tracks list fill and overflow, queues commands.
module smd_front #(
  parameter int LIST_DEPTH = smd_pkg::LIST_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  smd_in_if.sink        items,
  output logic          push_valid,
  input  logic          push_ready,
  output smd_pkg::cmd_t push_cmd
);
  import smd_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [CW-1:0] cnt_a;
  logic [CW-1:0] cnt_b;
  logic          ovf;
  logic          accept;
  logic          room_a;
  logic          room_b;

  // Ready follows the queue; dropped loads and unused op codes take no queue slot.
  assign items.ready = push_ready;
  assign accept      = items.valid && items.ready;
  assign room_a      = (cnt_a < CW'(LIST_DEPTH));
  assign room_b      = (cnt_b < CW'(LIST_DEPTH));

  // Classify the item and build the command.
  always_comb begin
    push_valid     = 1'b0;
    push_cmd.kind  = CMD_RUN;
    push_cmd.cnt_a = CNT_FIELD_W'(cnt_a);
    push_cmd.cnt_b = CNT_FIELD_W'(cnt_b);
    push_cmd.ovf   = ovf;
    push_cmd.key   = items.key;
    push_cmd.tag   = items.tag;
    unique case (items.op)
      OP_LOAD_A: begin
        push_cmd.kind = CMD_WR_A;
        push_valid    = accept && room_a;
      end
      OP_LOAD_B: begin
        push_cmd.kind  = CMD_WR_B;
        push_cmd.cnt_a = CNT_FIELD_W'(cnt_b);
        push_valid     = accept && room_b;
      end
      OP_RUN: begin
        push_cmd.kind = CMD_RUN;
        push_valid    = accept;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  // List counts and overflow flag; a run clears them all.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      unique case (items.op)
        OP_LOAD_A: begin
          if (room_a) begin
            cnt_a <= cnt_a + CW'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
        OP_LOAD_B: begin
          if (room_b) begin
            cnt_b <= cnt_b + CW'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
        OP_RUN: begin
          cnt_a <= '0;
          cnt_b <= '0;
          ovf   <= 1'b0;
        end
        default: begin
          ovf <= ovf;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/smd_back.sv
// Back part: holds both lists and walks them to emit the merged results.
module smd_back #(
  parameter int LIST_DEPTH = smd_pkg::LIST_DEPTH_DEF,
  parameter int TAG_WIDTH  = smd_pkg::TAG_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  smd_pkg::cmd_t cmd,
  smd_out_if.source     results
);
  import smd_pkg::*;

  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int TSW = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                    state;
  logic [CW-1:0]           ca;
  logic [CW-1:0]           cb;
  logic [CW-1:0]           i;
  logic [CW-1:0]           j;
  logic                    ovf;

  logic signed [KEY_W-1:0] a_keys [LIST_DEPTH];
  logic [TSW-1:0]          a_tags [LIST_DEPTH];
  logic signed [KEY_W-1:0] b_keys [LIST_DEPTH];
  logic [TSW-1:0]          b_tags [LIST_DEPTH];
  logic signed [KEY_W-1:0] head_a_key;
  logic [TSW-1:0]          head_a_tag;
  logic signed [KEY_W-1:0] head_b_key;
  logic [TSW-1:0]          head_b_tag;
  logic [AW-1:0]           rd_a_addr;
  logic [AW-1:0]           rd_b_addr;
  logic [AW-1:0]           wr_addr;

  logic                    pop;
  logic                    a_ok;
  logic                    b_ok;
  logic                    adv_i;
  logic                    adv_j;
  logic                    sel_b;
  logic                    empty;
  logic [CW-1:0]           i_next;
  logic [CW-1:0]           j_next;
  logic                    is_last;
  logic                    fire;
  logic [TAG_W-1:0]        tag_wide;

  logic                    out_valid;
  logic signed [KEY_W-1:0] out_key;
  logic [TAG_W-1:0]        out_tag;
  logic                    out_from_b;
  logic                    out_empty;
  logic                    out_dropped;
  logic                    out_last;

  // Commands are taken only between runs.
  assign cmd_ready = (state == ST_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign wr_addr   = cmd.cnt_a[AW-1:0];

  // Merge step: pick the smaller head, drop B's head on equal keys.
  always_comb begin
    a_ok  = (i < ca);
    b_ok  = (j < cb);
    adv_i = 1'b0;
    adv_j = 1'b0;
    sel_b = 1'b0;
    if (a_ok && b_ok) begin
      if (head_b_key < head_a_key) begin
        sel_b = 1'b1;
        adv_j = 1'b1;
      end else begin
        adv_i = 1'b1;
        adv_j = !(head_a_key < head_b_key);
      end
    end else if (a_ok) begin
      adv_i = 1'b1;
    end else if (b_ok) begin
      sel_b = 1'b1;
      adv_j = 1'b1;
    end
    empty   = !a_ok && !b_ok;
    i_next  = i + CW'(adv_i);
    j_next  = j + CW'(adv_j);
    is_last = (i_next == ca) && (j_next == cb);
  end

  // A result moves into the output register when it is free or being drained.
  assign fire = (state == ST_RUN) && (!out_valid || results.ready);

  // Read addresses look one step ahead so the heads are ready each cycle.
  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = '0;
    if (state == ST_RUN) begin
      rd_a_addr = fire ? i_next[AW-1:0] : i[AW-1:0];
      rd_b_addr = fire ? j_next[AW-1:0] : j[AW-1:0];
    end
  end

  // List memories with registered reads.
  always_ff @(posedge clk) begin
    if (pop && (cmd.kind == CMD_WR_A)) begin
      a_keys[wr_addr] <= cmd.key;
      a_tags[wr_addr] <= cmd.tag[TSW-1:0];
    end
    if (pop && (cmd.kind == CMD_WR_B)) begin
      b_keys[wr_addr] <= cmd.key;
      b_tags[wr_addr] <= cmd.tag[TSW-1:0];
    end
    head_a_key <= a_keys[rd_a_addr];
    head_a_tag <= a_tags[rd_a_addr];
    head_b_key <= b_keys[rd_b_addr];
    head_b_tag <= b_tags[rd_b_addr];
  end

  // Run sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop && (cmd.kind == CMD_RUN)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (fire && is_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Run indexes and the counts captured at the start of a run.
  always_ff @(posedge clk) begin
    if (pop && (cmd.kind == CMD_RUN)) begin
      ca  <= CW'(cmd.cnt_a);
      cb  <= CW'(cmd.cnt_b);
      ovf <= cmd.ovf;
      i   <= '0;
      j   <= '0;
    end else if (fire) begin
      i <= i_next;
      j <= j_next;
    end
  end

  // Selected tag, zero extended to the result field.
  always_comb begin
    tag_wide = '0;
    tag_wide[TSW-1:0] = sel_b ? head_b_tag : head_a_tag;
    if (empty) begin
      tag_wide = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_key     <= empty ? '0 : (sel_b ? head_b_key : head_a_key);
      out_tag     <= tag_wide;
      out_from_b  <= sel_b;
      out_empty   <= empty;
      out_dropped <= ovf;
      out_last    <= is_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.out_key     = out_key;
  assign results.out_tag     = out_tag;
  assign results.from_second = out_from_b;
  assign results.is_empty    = out_empty;
  assign results.dropped_any = out_dropped;
  assign results.last        = out_last;

endmodule

// File: hw/rtl/sorted_merge_dedup.sv
// Top level of the two-way sorted merge with duplicate removal.
// Items are taken at one per cycle whenever the four-entry command queue has room: a load
// into list A or B or a run occupies one queue slot (a dropped load or an unused op code
// takes none), and the back part writes each load into its list as it pops it. The back
// part takes no command while a run is walking, so queued commands wait for the run to end
// and the input stalls once four are queued. A run then emits one result per cycle while
// results are taken, max(1, merged entry count) results in all. With nothing queued ahead
// of it, the run passes through a queue slot, is taken by the back part once it is idle
// as the list heads are fetched into their read registers, and the first result is then
// registered; the single read port of each list memory sets this one-entry-per-cycle walk.
// Loads into a full list are dropped and reported through dropped_any on every result of the
// next run, and a run with both lists empty gives a single result marked is_empty and last.
module sorted_merge_dedup #(
  parameter int LIST_DEPTH = smd_pkg::LIST_DEPTH_DEF,
  parameter int TAG_WIDTH  = smd_pkg::TAG_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  smd_in_if.sink    items,
  smd_out_if.source results
);
  import smd_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Classify items and track list fill.
  smd_front #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  // Decoupling queue.
  smd_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  // List storage and merge walk.
  smd_back #(
    .LIST_DEPTH(LIST_DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(pop_valid),
    .cmd_ready(pop_ready),
    .cmd      (pop_cmd),
    .results  (results)
  );

endmodule

// File: hw/rtl/smd_checker.sv
// Port-level checker for the sorted merge block and its bind statement.
`include "sorted_merge_dedup_macros.svh"

module smd_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic signed [smd_pkg::KEY_W-1:0] out_key,
  input logic [smd_pkg::TAG_W-1:0] out_tag,
  input logic from_second,
  input logic is_empty,
  input logic last
);
  import smd_pkg::*;

  // A result waiting on a stalled sink stays offered.
  `SMD_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // An empty-run result is the only result of its run.
  `SMD_ASSERT_NOW(a_empty_last, clk, rst, out_valid && is_empty, last, "empty result not marked last")

  // An empty-run result carries a cleared entry from list A.
  `SMD_ASSERT_NOW(a_empty_clear, clk, rst, out_valid && is_empty, (out_key == '0) && (out_tag == '0) && !from_second, "empty result carries data")

  // Nothing is offered right after reset.
  `SMD_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !out_valid, "result offered after reset")

endmodule

bind sorted_merge_dedup smd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_key    (results.out_key),
  .out_tag    (results.out_tag),
  .from_second(results.from_second),
  .is_empty   (results.is_empty),
  .last       (results.last)
);

// File: verif/sorted_merge_dedup_tb.sv
// Self-checking testbench for the two-way sorted merge with duplicate removal.
module sorted_merge_dedup_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smd_pkg::*;

  localparam int LIST_DEPTH = LIST_DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam int RANDOM_ITEMS = 156;
  localparam int PHASE_ITEMS = RANDOM_ITEMS / 3;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIRECTED_N = 24;

  // One merged entry as it leaves the block.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic                    from_second;
    logic                    is_empty;
    logic                    dropped_any;
    logic                    last;
  } merge_out_t;

  // One row of the directed table; want is used only where has_want is set.
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic                    has_want;
    merge_out_t              want;
  } directed_row_t;

  localparam merge_out_t NO_WANT = '0;
  localparam merge_out_t EMPTY_RUN = '{32'd0, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b1};

  // Extremes, an unused op, duplicates across lists, signed ordering and unsorted lists.
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{OP_RUN,    32'd0,         16'h0000, 1'b1, EMPTY_RUN},
    '{OP_LOAD_A, KEY_MIN,       16'hFFFF, 1'b0, NO_WANT},
    '{OP_RUN,    32'd0,         16'h0000, 1'b1,
      '{KEY_MIN, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{OP_LOAD_B, KEY_MAX,       16'h0000, 1'b0, NO_WANT},
    '{OP_RUN,    KEY_MAX,       16'hFFFF, 1'b1,
      '{KEY_MAX, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{OP_UNUSED, 32'h1234_5678, 16'hBEEF, 1'b0, NO_WANT},
    '{OP_RUN,    32'd0,         16'h0000, 1'b1, EMPTY_RUN},
    '{OP_LOAD_A, -32'sd5,       16'h0001, 1'b0, NO_WANT},
    '{OP_LOAD_A, 32'sd0,        16'h0002, 1'b0, NO_WANT},
    '{OP_LOAD_A, 32'sd7,        16'h0003, 1'b0, NO_WANT},
    '{OP_LOAD_B, -32'sd5,       16'h0004, 1'b0, NO_WANT},
    '{OP_LOAD_B, 32'sd3,        16'h0005, 1'b0, NO_WANT},
    '{OP_LOAD_B, 32'sd7,        16'h0006, 1'b0, NO_WANT},
    '{OP_LOAD_B, 32'sd100,      16'h0007, 1'b0, NO_WANT},
    '{OP_RUN,    32'd0,         16'h0000, 1'b0, NO_WANT},
    '{OP_LOAD_A, 32'sd10,       16'h0008, 1'b0, NO_WANT},
    '{OP_LOAD_A, -32'sd20,      16'h0009, 1'b0, NO_WANT},
    '{OP_LOAD_B, 32'sd5,        16'h000A, 1'b0, NO_WANT},
    '{OP_LOAD_B, -32'sd30,      16'h000B, 1'b0, NO_WANT},
    '{OP_RUN,    32'd0,         16'h0000, 1'b0, NO_WANT},
    '{OP_LOAD_A, 32'h5555_5555, 16'hAAAA, 1'b0, NO_WANT},
    '{OP_LOAD_B, 32'hAAAA_AAAA, 16'h5555, 1'b0, NO_WANT},
    '{OP_LOAD_A, KEY_MAX,       16'h0001, 1'b0, NO_WANT},
    '{OP_RUN,    32'd0,         16'h0000, 1'b0, NO_WANT}
  };

  logic clk;
  logic rst;

  smd_in_if  item_ch();
  smd_out_if result_ch();

  sorted_merge_dedup i_dut (
    .clk(clk),
    .rst(rst),
    .items(item_ch),
    .results(result_ch)
  );

  // Shadow copy of both lists and the overflow flag.
  logic signed [KEY_W-1:0] list_a_keys [LIST_DEPTH];
  logic [TAG_W-1:0]        list_a_tags [LIST_DEPTH];
  logic signed [KEY_W-1:0] list_b_keys [LIST_DEPTH];
  logic [TAG_W-1:0]        list_b_tags [LIST_DEPTH];
  int   list_a_len = 0;
  int   list_b_len = 0;
  logic load_dropped = 1'b0;

  merge_out_t step_out [$];
  merge_out_t pending_out [$];
  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 18;
  int recv_idle_pct = 87;
  int hold_off_reqs = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic void emit_entry(logic signed [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                                     logic from_b, logic empty);
    merge_out_t r;
    r = '{k, t, from_b, empty, load_dropped, 1'b0};
    step_out.push_back(r);
  endfunction

  // Applies one accepted item to the shadow lists and collects the merged entries it emits.
  function automatic void predict_merge(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key,
                                        logic [TAG_W-1:0] tag);
    int i = 0;
    int j = 0;
    step_out.delete();
    case (op)
      OP_LOAD_A: begin
        if (list_a_len < LIST_DEPTH) begin
          list_a_keys[list_a_len] = key;
          list_a_tags[list_a_len] = tag;
          list_a_len++;
        end else begin
          load_dropped = 1'b1;
        end
      end
      OP_LOAD_B: begin
        if (list_b_len < LIST_DEPTH) begin
          list_b_keys[list_b_len] = key;
          list_b_tags[list_b_len] = tag;
          list_b_len++;
        end else begin
          load_dropped = 1'b1;
        end
      end
      OP_RUN: begin
        if (list_a_len == 0 && list_b_len == 0) begin
          emit_entry('0, '0, 1'b0, 1'b1);
        end else begin
          // Compare heads; on equal keys A wins and B's head is dropped.
          while (i < list_a_len && j < list_b_len) begin
            if (list_b_keys[j] < list_a_keys[i]) begin
              emit_entry(list_b_keys[j], list_b_tags[j], 1'b1, 1'b0);
              j++;
            end else begin
              emit_entry(list_a_keys[i], list_a_tags[i], 1'b0, 1'b0);
              if (list_a_keys[i] == list_b_keys[j]) j++;
              i++;
            end
          end
          // Tails are appended unchecked.
          while (i < list_a_len) begin
            emit_entry(list_a_keys[i], list_a_tags[i], 1'b0, 1'b0);
            i++;
          end
          while (j < list_b_len) begin
            emit_entry(list_b_keys[j], list_b_tags[j], 1'b1, 1'b0);
            j++;
          end
        end
        step_out[step_out.size() - 1].last = 1'b1;
        list_a_len = 0;
        list_b_len = 0;
        load_dropped = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Offers one item after a random gap and records what it should produce once taken.
  task automatic send_item(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key,
                           logic [TAG_W-1:0] tag, logic has_want, merge_out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op    <= op;
    item_ch.key   <= key;
    item_ch.tag   <= tag;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_merge(op, key, tag);
    if (has_want) begin
      pending_out.push_back(want);
    end else begin
      foreach (step_out[n]) pending_out.push_back(step_out[n]);
    end
  endtask

  // Loads two lists with random content and merges them. Most batches are short ascending
  // lists sharing some keys; a few fill the lists to near or past their depth or are unsorted.
  task automatic merge_batch(bit force_full);
    logic signed [KEY_W-1:0] keys_a [$];
    logic signed [KEY_W-1:0] keys_b [$];
    longint cur;
    int step_max;
    int want_a;
    int want_b;
    int pick;
    int mode;
    bit scrambled;
    mode = $urandom_range(0, 99);
    if (force_full) begin
      want_a = LIST_DEPTH + 2;
      want_b = LIST_DEPTH + 1;
    end else if (mode < 8) begin
      want_a = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 4);
      want_b = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 4);
    end else begin
      want_a = $urandom_range(0, 7);
      want_b = $urandom_range(0, 7);
    end
    scrambled = !force_full && mode >= 8 && mode < 20;
    case ($urandom_range(0, 2))
      0: cur = -64'sd2147483648;
      1: cur = longint'($urandom_range(0, 64)) - 32;
      default: cur = longint'($signed($urandom()));
    endcase
    step_max = $urandom_range(0, 1) ? 3 : 32'h0FFF_FFFF;

    // Walk upward through the key space, placing each key in A, B or both.
    while (keys_a.size() < want_a || keys_b.size() < want_b) begin
      cur += longint'($urandom_range(0, step_max));
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      pick = $urandom_range(0, 2);
      if (keys_a.size() >= want_a) pick = 1;
      else if (keys_b.size() >= want_b) pick = 0;
      if (pick != 1) keys_a.push_back(scrambled ? $urandom() : cur[KEY_W-1:0]);
      if (pick != 0) keys_b.push_back(scrambled ? $urandom() : cur[KEY_W-1:0]);
    end

    // Interleave the loads of both lists, with an occasional unused op in between.
    while (keys_a.size() + keys_b.size() > 0) begin
      if ($urandom_range(0, 99) < 4)
        send_item(OP_UNUSED, $urandom(), TAG_W'($urandom()), 1'b0, NO_WANT);
      if (keys_b.size() == 0 || (keys_a.size() > 0 && $urandom_range(0, 1))) begin
        send_item(OP_LOAD_A, keys_a.pop_front(), TAG_W'($urandom()), 1'b0, NO_WANT);
      end else begin
        send_item(OP_LOAD_B, keys_b.pop_front(), TAG_W'($urandom()), 1'b0, NO_WANT);
      end
      items_sent++;
    end
    send_item(OP_RUN, $urandom(), TAG_W'($urandom()), 1'b0, NO_WANT);
    items_sent++;
  endtask

  // Compares one taken result with the oldest pending entry.
  task automatic check_result();
    merge_out_t want;
    if (pending_out.size() == 0) begin
      report_mismatch($sformatf("unexpected result key %0d tag %h", result_ch.out_key,
                                result_ch.out_tag));
    end else begin
      want = pending_out.pop_front();
      // Key and tag carry no meaning on an empty run.
      if (!want.is_empty && result_ch.out_key !== want.key)
        report_mismatch($sformatf("out_key %0d, expected %0d", result_ch.out_key, want.key));
      if (!want.is_empty && result_ch.out_tag !== want.tag)
        report_mismatch($sformatf("out_tag %h, expected %h", result_ch.out_tag, want.tag));
      if (result_ch.from_second !== want.from_second)
        report_mismatch($sformatf("from_second %b, expected %b", result_ch.from_second,
                                  want.from_second));
      if (result_ch.is_empty !== want.is_empty)
        report_mismatch($sformatf("is_empty %b, expected %b", result_ch.is_empty,
                                  want.is_empty));
      if (result_ch.dropped_any !== want.dropped_any)
        report_mismatch($sformatf("dropped_any %b, expected %b", result_ch.dropped_any,
                                  want.dropped_any));
      if (result_ch.last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", result_ch.last, want.last));
    end
  endtask

  // Result side: checks each transfer and drives ready, with a long hold-off on request.
  initial begin : result_sink
    int hold_done;
    int hold_left;
    hold_done = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) check_result();
      if (hold_done != hold_off_reqs) begin
        hold_done = hold_off_reqs;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus: directed table, then random batches over three idling phases.
  initial begin : stimulus
    rst           <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.op    <= OP_LOAD_A;
    item_ch.key   <= '0;
    item_ch.tag   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int row = 0; row < DIRECTED_N; row++) begin
      send_item(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].key, DIRECTED_ROWS[row].tag,
                DIRECTED_ROWS[row].has_want, DIRECTED_ROWS[row].want);
    end

    // Sender idles lightly, receiver heavily; start with both lists overfilled.
    items_sent = 0;
    merge_batch(1'b1);
    while (items_sent < PHASE_ITEMS) merge_batch(1'b0);

    // Sender idles heavily, receiver lightly.
    send_idle_pct = 87;
    recv_idle_pct = 18;
    while (items_sent < 2 * PHASE_ITEMS) merge_batch(1'b0);

    // No idling; the receiver first holds off long enough for the input to back up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_reqs <= hold_off_reqs + 1;
    while (items_sent < RANDOM_ITEMS) merge_batch(1'b0);
    item_ch.valid <= 1'b0;

    // Drain and let any stray result show up.
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sorted_merge_dedup_tb: PASS");
    end else begin
      $display("sorted_merge_dedup_tb: FAIL");
    end
    $finish;
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("sorted_merge_dedup_tb: FAIL");
    $finish;
  end

endmodule
